[hw/rtl/msrf_pkg.sv]
// Shared types and constants of the multichannel sample ring FIFO.
// Used by the channel interfaces, the controller and the top level.
// Depends on nothing.
package msrf_pkg;

  localparam int KIND_W    = 3;
  localparam int COUNT_W   = 13;
  localparam int WORD_W    = 32;
  localparam int CH_W      = 4;
  localparam int NUM_LANES = 8;
  localparam int FILL_W    = 13;
  localparam int STATUS_W  = 2;

  localparam int DEPTH_DEF        = 4096;
  localparam int MAX_CHANNELS_DEF = 8;
  localparam int MAX_READ_DEF     = 64;

  typedef enum logic [KIND_W-1:0] {
    K_WRITE   = 3'd0,
    K_SILENCE = 3'd1,
    K_READ    = 3'd2,
    K_DISCARD = 3'd3,
    K_CLEAR   = 3'd4
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_NONE     = 2'd2
  } status_e;

  // Result load request from the controller to the output register.
  typedef struct packed {
    logic                load;
    logic                from_mem;
    logic                last;
    status_e             status;
    logic [FILL_W-1:0]   fill;
    logic [COUNT_W-1:0]  moved;
  } rsp_ctl_t;

endpackage

[hw/rtl/msrf_in_if.sv]
// Input channel of the sample ring FIFO: one operation per transaction.
// Depends on msrf_pkg for the field widths.
interface msrf_in_if;
  logic                          valid;
  logic                          ready;
  logic [msrf_pkg::KIND_W-1:0]   kind;
  logic [msrf_pkg::COUNT_W-1:0]  count;
  logic [msrf_pkg::WORD_W-1:0]   in_ch0;
  logic [msrf_pkg::WORD_W-1:0]   in_ch1;
  logic [msrf_pkg::WORD_W-1:0]   in_ch2;
  logic [msrf_pkg::WORD_W-1:0]   in_ch3;
  logic [msrf_pkg::WORD_W-1:0]   in_ch4;
  logic [msrf_pkg::WORD_W-1:0]   in_ch5;
  logic [msrf_pkg::WORD_W-1:0]   in_ch6;
  logic [msrf_pkg::WORD_W-1:0]   in_ch7;

  modport source (
    output valid, kind, count, in_ch0, in_ch1, in_ch2, in_ch3,
           in_ch4, in_ch5, in_ch6, in_ch7,
    input  ready
  );
  modport sink (
    input  valid, kind, count, in_ch0, in_ch1, in_ch2, in_ch3,
           in_ch4, in_ch5, in_ch6, in_ch7,
    output ready
  );
endinterface

[hw/rtl/msrf_out_if.sv]
// Output channel of the sample ring FIFO: one result frame per transaction.
// Depends on msrf_pkg for the field widths.
interface msrf_out_if;
  logic                           valid;
  logic                           ready;
  logic [msrf_pkg::WORD_W-1:0]    out_ch0;
  logic [msrf_pkg::WORD_W-1:0]    out_ch1;
  logic [msrf_pkg::WORD_W-1:0]    out_ch2;
  logic [msrf_pkg::WORD_W-1:0]    out_ch3;
  logic [msrf_pkg::WORD_W-1:0]    out_ch4;
  logic [msrf_pkg::WORD_W-1:0]    out_ch5;
  logic [msrf_pkg::WORD_W-1:0]    out_ch6;
  logic [msrf_pkg::WORD_W-1:0]    out_ch7;
  logic                           last;
  logic [msrf_pkg::STATUS_W-1:0]  status;
  logic [msrf_pkg::FILL_W-1:0]    fill_level;
  logic [msrf_pkg::COUNT_W-1:0]   moved_count;

  modport source (
    output valid, out_ch0, out_ch1, out_ch2, out_ch3, out_ch4, out_ch5,
           out_ch6, out_ch7, last, status, fill_level, moved_count,
    input  ready
  );
  modport sink (
    input  valid, out_ch0, out_ch1, out_ch2, out_ch3, out_ch4, out_ch5,
           out_ch6, out_ch7, last, status, fill_level, moved_count,
    output ready
  );
endinterface

[hw/rtl/multichannel_sample_ring_fifo_unit.sv]
// Top level of the multichannel sample ring FIFO: channel count register,
// frame store, controller and output register.
// Depends on msrf_pkg, msrf_in_if, msrf_out_if, msrf_ram and msrf_ctrl.
//
//   Channel   Direction  Handshake          Carries
//   item_i    in         valid/ready        kind, count, in_ch0..in_ch7
//   result_o  out        valid/ready        out_ch0..7, last, status, fill, moved
//   cfg       in         cfg_we_i only      channel count
//
// A write frame, discard, clear or refused operation loads its result into the output register as it is accepted.
// A read of n frames delivers one frame a cycle while results are taken; the
// single port of the frame store and its registered read port set this pace.
// Silence of n frames returns its result at once, then writes n zero rows,
// one a cycle through the same port, before the next transaction is taken.
// Reset clears pointers, fill level and channel count; the frame store is not
// cleared. Back-pressure on result_o stalls the read sequence in place.
module multichannel_sample_ring_fifo_unit #(
  parameter int DEPTH        = msrf_pkg::DEPTH_DEF,
  parameter int MAX_CHANNELS = msrf_pkg::MAX_CHANNELS_DEF,
  parameter int MAX_READ     = msrf_pkg::MAX_READ_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [msrf_pkg::CH_W-1:0]   cfg_wdata_i,
  msrf_in_if.sink                     item_i,
  msrf_out_if.source                  result_o
);
  import msrf_pkg::*;

  localparam int ROW_W = MAX_CHANNELS * WORD_W;
  localparam int PTR_W = $clog2(DEPTH);

  logic [CH_W-1:0]   chan_cnt_q;
  logic [CH_W-1:0]   chans;
  logic              slot_free;
  rsp_ctl_t          rsp;

  logic              ram_we, ram_re;
  logic [PTR_W-1:0]  ram_addr;
  logic [ROW_W-1:0]  ram_wdata, ram_rdata;

  logic [NUM_LANES-1:0][WORD_W-1:0] lane_word;
  logic [NUM_LANES-1:0][WORD_W-1:0] out_words_q;
  logic                             out_valid_q, out_valid_d;
  logic                             out_last_q;
  status_e                          out_status_q;
  logic [FILL_W-1:0]                out_fill_q;
  logic [COUNT_W-1:0]               out_moved_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_cnt_q <= '0;
    end else if (cfg_we_i) begin
      chan_cnt_q <= cfg_wdata_i;
    end
  end

  assign chans = (chan_cnt_q > CH_W'(MAX_CHANNELS)) ? CH_W'(MAX_CHANNELS) : chan_cnt_q;

  assign slot_free = !out_valid_q || result_o.ready;

  msrf_ctrl #(
    .DEPTH        (DEPTH),
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_READ     (MAX_READ)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .chans_i     (chans),
    .slot_free_i (slot_free),
    .item_i      (item_i),
    .ram_we_o    (ram_we),
    .ram_re_o    (ram_re),
    .ram_addr_o  (ram_addr),
    .ram_wdata_o (ram_wdata),
    .rsp_o       (rsp)
  );

  msrf_ram #(
    .WIDTH (ROW_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Lanes beyond the active channel count read as zero.
  for (genvar c = 0; c < NUM_LANES; c++) begin : g_lane
    if (c < MAX_CHANNELS) begin : g_used
      assign lane_word[c] = (rsp.from_mem && (CH_W'(c) < chans)) ?
                            ram_rdata[c*WORD_W +: WORD_W] : '0;
    end else begin : g_unused
      assign lane_word[c] = '0;
    end
  end

  assign out_valid_d = rsp.load ? 1'b1 : (result_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp.load) begin
      out_words_q  <= lane_word;
      out_last_q   <= rsp.last;
      out_status_q <= rsp.status;
      out_fill_q   <= rsp.fill;
      out_moved_q  <= rsp.moved;
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.out_ch0     = out_words_q[0];
  assign result_o.out_ch1     = out_words_q[1];
  assign result_o.out_ch2     = out_words_q[2];
  assign result_o.out_ch3     = out_words_q[3];
  assign result_o.out_ch4     = out_words_q[4];
  assign result_o.out_ch5     = out_words_q[5];
  assign result_o.out_ch6     = out_words_q[6];
  assign result_o.out_ch7     = out_words_q[7];
  assign result_o.last        = out_last_q;
  assign result_o.status      = STATUS_W'(out_status_q);
  assign result_o.fill_level  = out_fill_q;
  assign result_o.moved_count = out_moved_q;

  // A refused or empty operation moves nothing.
  a_fail_moves_nothing : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && (result_o.status != ST_OK) |-> (result_o.moved_count == '0))
    else $error("non-ok result reports moved frames");

  // Only a read produces more than one result, so any other result is final.
  a_fail_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && (result_o.status != ST_OK) |-> result_o.last)
    else $error("non-ok result is not the last of its transaction");

  // No new transaction is taken while a read sequence is still delivering.
  a_no_accept_mid_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && !result_o.last |-> !item_i.ready)
    else $error("input accepted in the middle of a read sequence");

  // A read frame never appears on the output without a frame having been taken.
  a_read_after_issue : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.from_mem |-> $past(ram_re) || $past(rsp.from_mem) || !$past(slot_free))
    else $error("frame store data used without a preceding read");
endmodule

[hw/rtl/msrf_ram.sv]
// Generic single-port synchronous RAM with a registered read port.
// Standalone; no package dependency.
module msrf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

[hw/rtl/msrf_ctrl.sv]
// Controller of the sample ring FIFO: pointers, fill level, sequencing of
// frame store accesses and result requests. Depends on msrf_pkg and msrf_in_if.
module msrf_ctrl #(
  parameter int DEPTH        = msrf_pkg::DEPTH_DEF,
  parameter int MAX_CHANNELS = msrf_pkg::MAX_CHANNELS_DEF,
  parameter int MAX_READ     = msrf_pkg::MAX_READ_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [msrf_pkg::CH_W-1:0]           chans_i,
  input  logic                                slot_free_i,
  msrf_in_if.sink                             item_i,
  output logic                                ram_we_o,
  output logic                                ram_re_o,
  output logic [$clog2(DEPTH)-1:0]            ram_addr_o,
  output logic [MAX_CHANNELS*msrf_pkg::WORD_W-1:0] ram_wdata_o,
  output msrf_pkg::rsp_ctl_t                  rsp_o
);
  import msrf_pkg::*;

  localparam int PTR_W  = $clog2(DEPTH);
  localparam int HELD_W = $clog2(DEPTH + 1);
  localparam int RD_W   = $clog2(MAX_READ + 1);
  localparam int SUM_W  = ((HELD_W > COUNT_W) ? HELD_W : COUNT_W) + 1;
  localparam int ROW_W  = MAX_CHANNELS * WORD_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_FILL = 3'b100
  } state_e;

  state_e              state_q, state_d;
  logic [PTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [HELD_W-1:0]   held_q, held_d;
  logic [COUNT_W-1:0]  fill_left_q, fill_left_d;
  logic [RD_W-1:0]     rd_total_q, rd_total_d;
  logic [RD_W-1:0]     rd_issued_q, rd_issued_d;
  logic [RD_W-1:0]     rd_done_q, rd_done_d;
  logic                pend_q, pend_d;

  logic                in_ready;
  logic                accept;
  logic [SUM_W-1:0]    held_ext, cnt_ext, avail, silence_sum;
  logic [RD_W-1:0]     rd_n;
  logic [HELD_W:0]     disc_sum;
  logic [PTR_W-1:0]    wr_ptr_inc, rd_ptr_inc, rd_ptr_disc;
  logic [RD_W-1:0]     done_inc;
  logic                emit, issue;

  logic [NUM_LANES-1:0][WORD_W-1:0] in_words;
  logic [ROW_W-1:0]                 wrow;

  assign in_words = {item_i.in_ch7, item_i.in_ch6, item_i.in_ch5, item_i.in_ch4,
                     item_i.in_ch3, item_i.in_ch2, item_i.in_ch1, item_i.in_ch0};

  for (genvar c = 0; c < MAX_CHANNELS; c++) begin : g_row
    assign wrow[c*WORD_W +: WORD_W] = in_words[c];
  end

  assign in_ready     = (state_q == S_IDLE) && slot_free_i;
  assign item_i.ready = in_ready;
  assign accept       = item_i.valid && in_ready;

  assign held_ext    = SUM_W'(held_q);
  assign cnt_ext     = SUM_W'(item_i.count);
  assign avail       = (cnt_ext < held_ext) ? cnt_ext : held_ext;
  assign rd_n        = (avail > SUM_W'(MAX_READ)) ? RD_W'(MAX_READ) : RD_W'(avail);
  assign silence_sum = held_ext + cnt_ext;

  assign wr_ptr_inc = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
  assign rd_ptr_inc = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;

  // The discarded count never exceeds the fill level, so one wrap suffices.
  always_comb begin
    disc_sum = (HELD_W+1)'(rd_ptr_q) + (HELD_W+1)'(HELD_W'(avail));
    if (disc_sum >= (HELD_W+1)'(DEPTH)) begin
      disc_sum = disc_sum - (HELD_W+1)'(DEPTH);
    end
    rd_ptr_disc = PTR_W'(disc_sum);
  end

  assign done_inc = rd_done_q + 1'b1;
  assign emit     = (state_q == S_READ) && pend_q && slot_free_i;
  assign issue    = (state_q == S_READ) && (rd_issued_q != rd_total_q) && (!pend_q || emit);

  assign ram_wdata_o = (state_q == S_FILL) ? '0 : wrow;

  always_comb begin
    state_d     = state_q;
    wr_ptr_d    = wr_ptr_q;
    rd_ptr_d    = rd_ptr_q;
    held_d      = held_q;
    fill_left_d = fill_left_q;
    rd_total_d  = rd_total_q;
    rd_issued_d = rd_issued_q;
    rd_done_d   = rd_done_q;
    pend_d      = pend_q;
    ram_we_o    = 1'b0;
    ram_re_o    = 1'b0;
    ram_addr_o  = wr_ptr_q;

    rsp_o.load     = 1'b0;
    rsp_o.from_mem = 1'b0;
    rsp_o.last     = 1'b1;
    rsp_o.status   = ST_NONE;
    rsp_o.fill     = FILL_W'(held_q);
    rsp_o.moved    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (cfg_we_i) begin
          wr_ptr_d = '0;
          rd_ptr_d = '0;
          held_d   = '0;
        end else if (accept) begin
          rsp_o.load = 1'b1;
          if (chans_i == '0) begin
            rsp_o.status = ST_NONE;
          end else begin
            unique case (item_i.kind)
              K_WRITE: begin
                if (held_q == HELD_W'(DEPTH)) begin
                  rsp_o.status = ST_OVERFLOW;
                end else begin
                  ram_we_o     = 1'b1;
                  ram_addr_o   = wr_ptr_q;
                  wr_ptr_d     = wr_ptr_inc;
                  held_d       = held_q + 1'b1;
                  rsp_o.status = ST_OK;
                  rsp_o.moved  = COUNT_W'(1);
                  rsp_o.fill   = FILL_W'(held_q + 1'b1);
                end
              end
              K_SILENCE: begin
                if (item_i.count == '0) begin
                  rsp_o.status = ST_NONE;
                end else if (silence_sum > SUM_W'(DEPTH)) begin
                  rsp_o.status = ST_OVERFLOW;
                end else begin
                  // The result goes out at once; the zero frames are written
                  // afterwards while input is held off.
                  held_d       = HELD_W'(silence_sum);
                  fill_left_d  = item_i.count;
                  state_d      = S_FILL;
                  rsp_o.status = ST_OK;
                  rsp_o.moved  = item_i.count;
                  rsp_o.fill   = FILL_W'(silence_sum);
                end
              end
              K_READ: begin
                if (rd_n == '0) begin
                  rsp_o.status = ST_NONE;
                end else begin
                  rsp_o.load  = 1'b0;
                  ram_re_o    = 1'b1;
                  ram_addr_o  = rd_ptr_q;
                  rd_ptr_d    = rd_ptr_inc;
                  rd_total_d  = rd_n;
                  rd_issued_d = RD_W'(1);
                  rd_done_d   = '0;
                  pend_d      = 1'b1;
                  state_d     = S_READ;
                end
              end
              K_DISCARD: begin
                if (avail == '0) begin
                  rsp_o.status = ST_NONE;
                end else begin
                  held_d       = held_q - HELD_W'(avail);
                  rd_ptr_d     = rd_ptr_disc;
                  rsp_o.status = ST_OK;
                  rsp_o.moved  = COUNT_W'(avail);
                  rsp_o.fill   = FILL_W'(held_q - HELD_W'(avail));
                end
              end
              K_CLEAR: begin
                held_d       = '0;
                wr_ptr_d     = '0;
                rd_ptr_d     = '0;
                rsp_o.status = ST_OK;
                rsp_o.fill   = '0;
              end
              default: begin
                rsp_o.status = ST_NONE;
              end
            endcase
          end
        end
      end

      S_READ: begin
        // Frame store data for the oldest issued read is pending; the next
        // read is issued in the cycle the pending frame leaves.
        if (emit) begin
          rsp_o.load     = 1'b1;
          rsp_o.from_mem = 1'b1;
          rsp_o.status   = ST_OK;
          rsp_o.last     = (done_inc == rd_total_q);
          rsp_o.moved    = COUNT_W'(done_inc);
          rsp_o.fill     = FILL_W'(held_q - 1'b1);
          held_d         = held_q - 1'b1;
          rd_done_d      = done_inc;
          if (done_inc == rd_total_q) begin
            state_d = S_IDLE;
          end
        end
        if (issue) begin
          ram_re_o    = 1'b1;
          ram_addr_o  = rd_ptr_q;
          rd_ptr_d    = rd_ptr_inc;
          rd_issued_d = rd_issued_q + 1'b1;
        end
        pend_d = issue ? 1'b1 : (emit ? 1'b0 : pend_q);
      end

      S_FILL: begin
        ram_we_o    = 1'b1;
        ram_addr_o  = wr_ptr_q;
        wr_ptr_d    = wr_ptr_inc;
        fill_left_d = fill_left_q - 1'b1;
        if (fill_left_q == COUNT_W'(1)) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      held_q      <= '0;
      fill_left_q <= '0;
      rd_total_q  <= '0;
      rd_issued_q <= '0;
      rd_done_q   <= '0;
      pend_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      wr_ptr_q    <= wr_ptr_d;
      rd_ptr_q    <= rd_ptr_d;
      held_q      <= held_d;
      fill_left_q <= fill_left_d;
      rd_total_q  <= rd_total_d;
      rd_issued_q <= rd_issued_d;
      rd_done_q   <= rd_done_d;
      pend_q      <= pend_d;
    end
  end
endmodule

[dv/tb_multichannel_sample_ring_fifo_unit.sv]
// Self-checking testbench of the multichannel sample ring FIFO unit.
// Keeps its own frame queue to predict every result, and checks each result transaction.
// Depends on msrf_pkg, msrf_in_if, msrf_out_if and the unit under test.
module tb_multichannel_sample_ring_fifo_unit;
  import msrf_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int FIFO_DEPTH     = DEPTH_DEF;
  localparam int LANE_LIMIT     = MAX_CHANNELS_DEF;
  localparam int READ_LIMIT     = MAX_READ_DEF;
  // A silence transaction may keep the unit busy for a whole ring of rows.
  localparam int SETTLE_CYCLES  = FIFO_DEPTH + 16;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef logic [NUM_LANES-1:0][WORD_W-1:0] frame_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [COUNT_W-1:0] count;
    frame_t             words;
  } op_t;

  typedef struct packed {
    frame_t             words;
    logic               last;
    status_e            status;
    logic [FILL_W-1:0]  fill;
    logic [COUNT_W-1:0] moved;
  } result_t;

  typedef enum {
    PACE_STEADY,
    PACE_SENDER_GAPS,
    PACE_RECEIVER_STALLS,
    PACE_BOTH
  } pace_e;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CH_W-1:0]    cfg_wdata_i;

  msrf_in_if  item_bus ();
  msrf_out_if result_bus ();

  multichannel_sample_ring_fifo_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item_bus),
    .result_o    (result_bus)
  );

  // Predicted state of the ring: the frames held, oldest first, and the active lanes.
  frame_t      held_frames[$];
  int unsigned active_lanes = 0;
  result_t     pending_results[$];

  pace_e       pace = PACE_STEADY;
  int unsigned ready_hold_left = 0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic void apply_operation(op_t op);
    result_t     res;
    frame_t      frame;
    int unsigned held;
    int unsigned n;
    int unsigned i;
    int          lane;
    held = held_frames.size();
    res = '0;
    res.last = 1'b1;
    res.status = ST_NONE;
    if (active_lanes != 0 && op.kind <= K_CLEAR) begin
      case (op.kind)
        K_WRITE: begin
          if (held + 1 > FIFO_DEPTH) begin
            res.status = ST_OVERFLOW;
          end else begin
            frame = '0;
            for (lane = 0; lane < active_lanes; lane++) frame[lane] = op.words[lane];
            held_frames.push_back(frame);
            res.status = ST_OK;
            res.moved = COUNT_W'(1);
          end
        end
        K_SILENCE: begin
          if (op.count == 0) begin
            res.status = ST_NONE;
          end else if (held + op.count > FIFO_DEPTH) begin
            res.status = ST_OVERFLOW;
          end else begin
            repeat (op.count) held_frames.push_back('0);
            res.status = ST_OK;
            res.moved = op.count;
          end
        end
        K_READ: begin
          n = (op.count < held) ? op.count : held;
          if (n > READ_LIMIT) n = READ_LIMIT;
          // A read gives one result per frame; only the final one carries last.
          for (i = 0; i < n; i++) begin
            res.words = held_frames.pop_front();
            res.status = ST_OK;
            res.moved = COUNT_W'(i + 1);
            res.last = (i + 1 == n);
            res.fill = FILL_W'(held_frames.size());
            pending_results.push_back(res);
          end
          if (n != 0) return;
        end
        K_DISCARD: begin
          n = (op.count < held) ? op.count : held;
          if (n != 0) begin
            repeat (n) void'(held_frames.pop_front());
            res.status = ST_OK;
            res.moved = COUNT_W'(n);
          end
        end
        default: begin
          held_frames.delete();
          res.status = ST_OK;
        end
      endcase
    end
    res.fill = FILL_W'(held_frames.size());
    pending_results.push_back(res);
  endfunction

  function automatic void report_field(string field, logic [WORD_W-1:0] want,
                                       logic [WORD_W-1:0] got);
    $display("%0t: mismatch on %s: expected %h, actual %h", $time, field, want, got);
    mismatch_count++;
  endfunction

  function automatic void check_result(result_t got);
    result_t want;
    int      lane;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result: expected none, actual %h", $time, got);
      mismatch_count++;
      return;
    end
    want = pending_results.pop_front();
    for (lane = 0; lane < NUM_LANES; lane++) begin
      if (got.words[lane] !== want.words[lane])
        report_field($sformatf("out_ch%0d", lane), want.words[lane], got.words[lane]);
    end
    if (got.last !== want.last)
      report_field("last", WORD_W'(want.last), WORD_W'(got.last));
    if (got.status !== want.status)
      report_field("status", WORD_W'(want.status), WORD_W'(got.status));
    if (got.fill !== want.fill)
      report_field("fill_level", WORD_W'(want.fill), WORD_W'(got.fill));
    if (got.moved !== want.moved)
      report_field("moved_count", WORD_W'(want.moved), WORD_W'(got.moved));
  endfunction

  // Both handshakes are observed here so that prediction always precedes checking.
  always @(posedge clk_i) begin
    op_t     seen_op;
    result_t seen_res;
    if (rst_ni) begin
      if (item_bus.valid && item_bus.ready) begin
        seen_op.kind  = item_bus.kind;
        seen_op.count = item_bus.count;
        seen_op.words = {item_bus.in_ch7, item_bus.in_ch6, item_bus.in_ch5, item_bus.in_ch4,
                         item_bus.in_ch3, item_bus.in_ch2, item_bus.in_ch1, item_bus.in_ch0};
        apply_operation(seen_op);
      end
      if (result_bus.valid && result_bus.ready) begin
        seen_res.words  = {result_bus.out_ch7, result_bus.out_ch6, result_bus.out_ch5,
                           result_bus.out_ch4, result_bus.out_ch3, result_bus.out_ch2,
                           result_bus.out_ch1, result_bus.out_ch0};
        seen_res.last   = result_bus.last;
        seen_res.status = status_e'(result_bus.status);
        seen_res.fill   = result_bus.fill_level;
        seen_res.moved  = result_bus.moved_count;
        check_result(seen_res);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("tb_multichannel_sample_ring_fifo_unit: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result receiver: a requested hold-off takes precedence over the random stalls.
  always @(negedge clk_i) begin
    int unsigned stall_pct;
    stall_pct = (pace == PACE_RECEIVER_STALLS) ? 67 : (pace == PACE_BOTH) ? 33 : 0;
    if (ready_hold_left != 0) begin
      result_bus.ready <= 1'b0;
      ready_hold_left = ready_hold_left - 1;
    end else begin
      result_bus.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_operation(input op_t op);
    int unsigned gap_pct;
    gap_pct = (pace == PACE_SENDER_GAPS) ? 67 : (pace == PACE_BOTH) ? 33 : 0;
    while ($urandom_range(99) < gap_pct) begin
      @(negedge clk_i);
      item_bus.valid <= 1'b0;
      item_bus.kind  <= KIND_W'($urandom());
      item_bus.count <= COUNT_W'($urandom());
    end
    @(negedge clk_i);
    item_bus.valid  <= 1'b1;
    item_bus.kind   <= op.kind;
    item_bus.count  <= op.count;
    item_bus.in_ch0 <= op.words[0];
    item_bus.in_ch1 <= op.words[1];
    item_bus.in_ch2 <= op.words[2];
    item_bus.in_ch3 <= op.words[3];
    item_bus.in_ch4 <= op.words[4];
    item_bus.in_ch5 <= op.words[5];
    item_bus.in_ch6 <= op.words[6];
    item_bus.in_ch7 <= op.words[7];
    do @(posedge clk_i); while (!item_bus.ready);
  endtask

  task automatic wait_for_drain();
    @(negedge clk_i);
    item_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_channel_count(input logic [CH_W-1:0] channels);
    wait_for_drain();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= channels;
    active_lanes = (channels > LANE_LIMIT) ? LANE_LIMIT : channels;
    held_frames.delete();
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic op_t make_op(logic [KIND_W-1:0] kind, int unsigned count,
                                  logic [WORD_W-1:0] word);
    op_t op;
    op.kind  = kind;
    op.count = COUNT_W'(count);
    op.words = {NUM_LANES{word}};
    return op;
  endfunction

  // Mostly well-formed traffic that keeps the ring partly filled, with occasional
  // exact fills, overflows, zero counts, full-width counts and unknown kinds.
  function automatic op_t random_operation();
    op_t         op;
    int unsigned held;
    int unsigned pick;
    int unsigned shape;
    int          lane;
    held = held_frames.size();
    shape = $urandom_range(9);
    for (lane = 0; lane < NUM_LANES; lane++) begin
      if (shape == 0) op.words[lane] = '1;
      else if (shape == 1) op.words[lane] = '0;
      else op.words[lane] = $urandom();
    end
    op.count = COUNT_W'($urandom());
    shape = $urandom_range(9);
    pick = $urandom_range(99);
    if (pick < 35) begin
      op.kind = K_WRITE;
    end else if (pick < 60) begin
      op.kind = K_READ;
      if (shape < 6) op.count = COUNT_W'($urandom_range(1, 8));
      else if (shape < 8) op.count = COUNT_W'($urandom_range(9, READ_LIMIT + 8));
      else if (shape == 8) op.count = '0;
    end else if (pick < 68) begin
      op.kind = K_DISCARD;
      if (shape < 7) op.count = COUNT_W'($urandom_range(1, 4));
      else if (shape == 7) op.count = '0;
    end else if (pick < 82) begin
      op.kind = K_SILENCE;
      if (shape < 6) op.count = COUNT_W'($urandom_range(1, 12));
      else if (shape == 6) op.count = COUNT_W'(FIFO_DEPTH - held);
      else if (shape == 7) op.count = COUNT_W'(FIFO_DEPTH - held + 1);
      else if (shape == 8) op.count = '0;
    end else if (pick < 88) begin
      op.kind = K_CLEAR;
    end else if (pick < 93) begin
      op.kind = KIND_W'($urandom_range(K_CLEAR + 1, (1 << KIND_W) - 1));
    end else begin
      op.kind = K_WRITE;
    end
    return op;
  endfunction

  task automatic test_idle_channels();
    set_channel_count(0);
    send_operation(make_op(K_WRITE, 0, '1));
    send_operation(make_op(K_SILENCE, 5, '0));
    send_operation(make_op(K_READ, 3, '0));
    send_operation(make_op(K_CLEAR, 0, '0));
    send_operation(make_op(KIND_W'(7), 1, '0));
  endtask

  task automatic test_basic_operations();
    op_t op;
    int  lane;
    set_channel_count(8);
    send_operation(make_op(K_WRITE, 0, '1));
    send_operation(make_op(K_WRITE, 0, '0));
    send_operation(make_op(K_WRITE, 0, 32'hA5A5_5A5A));
    send_operation(make_op(K_READ, 0, '0));
    send_operation(make_op(K_READ, 1, '0));
    send_operation(make_op(K_READ, 8191, '0));
    send_operation(make_op(K_READ, 4, '0));
    send_operation(make_op(K_DISCARD, 1, '0));
    send_operation(make_op(K_SILENCE, 0, '1));
    send_operation(make_op(K_SILENCE, 3, '1));
    send_operation(make_op(K_DISCARD, 0, '0));
    send_operation(make_op(K_DISCARD, 8191, '0));
    op = make_op(K_WRITE, 0, '0);
    for (lane = 0; lane < NUM_LANES; lane++) op.words[lane] = $urandom();
    send_operation(op);
    send_operation(make_op(KIND_W'(5), 2, '0));
    send_operation(make_op(K_CLEAR, 0, '0));
  endtask

  // A channel count above the lane limit saturates; the ring is filled to capacity here.
  task automatic test_full_ring();
    set_channel_count(15);
    send_operation(make_op(K_SILENCE, FIFO_DEPTH, '0));
    send_operation(make_op(K_WRITE, 0, '1));
    send_operation(make_op(K_SILENCE, 1, '0));
    send_operation(make_op(K_READ, 100, '0));
    send_operation(make_op(K_DISCARD, 8191, '0));
    send_operation(make_op(K_SILENCE, FIFO_DEPTH + 1, '0));
    send_operation(make_op(K_CLEAR, 0, '0));
  endtask

  task automatic test_random_traffic(input logic [CH_W-1:0] channels, input pace_e p,
                                     input int unsigned items);
    set_channel_count(channels);
    pace = p;
    repeat (items) send_operation(random_operation());
  endtask

  // The receiver holds off long enough for the result path to fill and stall the input.
  task automatic test_result_backpressure();
    set_channel_count(2);
    pace = PACE_STEADY;
    ready_hold_left = 300;
    repeat (40) send_operation(random_operation());
  endtask

  initial begin
    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = '0;
    item_bus.valid   = 1'b0;
    item_bus.kind    = '0;
    item_bus.count   = '0;
    item_bus.in_ch0  = '0;
    item_bus.in_ch1  = '0;
    item_bus.in_ch2  = '0;
    item_bus.in_ch3  = '0;
    item_bus.in_ch4  = '0;
    item_bus.in_ch5  = '0;
    item_bus.in_ch6  = '0;
    item_bus.in_ch7  = '0;
    result_bus.ready = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_idle_channels();
    test_basic_operations();
    test_full_ring();
    test_random_traffic(3, PACE_STEADY, 100);
    test_random_traffic(1, PACE_SENDER_GAPS, 100);
    test_random_traffic(6, PACE_RECEIVER_STALLS, 100);
    test_random_traffic(8, PACE_BOTH, 100);
    test_result_backpressure();

    wait_for_drain();
    if (mismatch_count == 0) begin
      $display("tb_multichannel_sample_ring_fifo_unit: PASS");
    end else begin
      $display("tb_multichannel_sample_ring_fifo_unit: FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/msrf_pkg.sv
hw/rtl/msrf_in_if.sv
hw/rtl/msrf_out_if.sv
hw/rtl/msrf_ram.sv
hw/rtl/msrf_ctrl.sv
hw/rtl/multichannel_sample_ring_fifo_unit.sv
dv/tb_multichannel_sample_ring_fifo_unit.sv
